FILE: rtl/rbdq_pkg.sv
// shared constants and types for the ring buffer deque
`default_nettype none
package rbdq_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;

    localparam logic [FUNC_W-1:0] FUNC_IDLE       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

    localparam logic [WORD_W-1:0] NO_WORD = '1;

    typedef struct packed {
        logic latch_in;
        logic apply_op;
        logic rd_ends;
        logic load_out;
    } rbdq_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/rbdq_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module rbdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic                     rd_en_b,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_a)
        begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rbdq_ctrl.sv
// sequencing state machine for the ring buffer deque
`default_nettype none
module rbdq_ctrl
    import rbdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output rbdq_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POPRD = 4'b0010,
        S_ENDRD = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_POPRD;
                end
            end
            S_POPRD:
            begin
                cmd.apply_op = 1'b1;
                state_next   = S_ENDRD;
            end
            S_ENDRD:
            begin
                cmd.rd_ends = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/rbdq_dp.sv
// datapath: indices, fill count, word store and result register
`default_nettype none
module rbdq_dp
    import rbdq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rbdq_cmd_t                cmd,
    input  wire logic        [FUNC_W-1:0] func,
    input  wire logic signed [WORD_W-1:0] push_word,
    output logic signed      [WORD_W-1:0] popped_word,
    output logic signed      [WORD_W-1:0] head_word,
    output logic signed      [WORD_W-1:0] tail_word,
    output logic             [6:0]        count,
    output logic                          is_empty,
    output logic                          overflow
);

    logic [FUNC_W-1:0] func_reg;
    logic [WORD_W-1:0] word_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop_ok_reg, pop_ok_next;
    logic              ovf_reg, ovf_next;
    logic [WORD_W-1:0] pop_word_reg;
    logic              pop_cap_reg;

    logic [WORD_W-1:0] popped_reg, head_w_reg, tail_w_reg;
    logic [6:0]        count_reg;
    logic              empty_reg, ovf_out_reg;

    logic [IDX_W-1:0]  head_m1, head_p1, tail_m1, tail_p1;
    logic              full, is_push;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en_a;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [WORD_W-1:0] rd_data_a, rd_data_b;

    assign head_m1 = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_p1 = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_m1 = (tail_reg == '0) ? IDX_W'(DEPTH - 1) : tail_reg - 1'b1;
    assign tail_p1 = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign is_push = (func_reg == FUNC_PUSH_FRONT) || (func_reg == FUNC_PUSH_BACK);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        pop_ok_next = pop_ok_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        if (cmd.apply_op)
        begin
            pop_ok_next = 1'b0;
            ovf_next    = is_push && full;
            case (func_reg)
                FUNC_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        head_next = head_m1;
                        wr_en     = 1'b1;
                        wr_addr   = head_m1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                FUNC_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        tail_next = tail_p1;
                        wr_en     = 1'b1;
                        wr_addr   = tail_reg;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (cnt_reg != '0)
                    begin
                        head_next   = head_p1;
                        cnt_next    = cnt_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (cnt_reg != '0)
                    begin
                        tail_next   = tail_m1;
                        cnt_next    = cnt_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                    cnt_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // pop address on apply, front index when fetching the end words
    assign rd_en_a   = cmd.apply_op || cmd.rd_ends;
    assign rd_addr_a = (cmd.apply_op && (func_reg == FUNC_POP_BACK)) ? tail_m1 : head_reg;

    rbdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (word_reg),
        .rd_en_a   (rd_en_a),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_en_b   (cmd.rd_ends),
        .rd_addr_b (tail_m1),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            pop_ok_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            pop_cap_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            pop_ok_reg  <= pop_ok_next;
            ovf_reg     <= ovf_next;
            pop_cap_reg <= cmd.apply_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= func;
            word_reg <= push_word;
        end
        if (pop_cap_reg)
        begin
            pop_word_reg <= rd_data_a;
        end
        if (cmd.load_out)
        begin
            popped_reg  <= pop_ok_reg ? pop_word_reg : NO_WORD;
            head_w_reg  <= (cnt_reg != '0) ? rd_data_a : NO_WORD;
            tail_w_reg  <= (cnt_reg != '0) ? rd_data_b : NO_WORD;
            count_reg   <= 7'(cnt_reg);
            empty_reg   <= (cnt_reg == '0);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign popped_word = signed'(popped_reg);
    assign head_word   = signed'(head_w_reg);
    assign tail_word   = signed'(tail_w_reg);
    assign count       = count_reg;
    assign is_empty    = empty_reg;
    assign overflow    = ovf_out_reg;

endmodule
`default_nettype wire

FILE: rtl/ring_buffer_deque_top.sv
// top level of the ring buffer deque
//
// double-ended queue of signed 32-bit words in a 64-entry circular store.
// input channel (in_valid / in_ready) carries one operation per item:
// func selects idle, push front, push back, pop front, pop back or clear,
// push_word is the word for a push. codes 6 and 7 act as idle.
// output channel (out_valid / out_ready) returns one result per item:
// popped word (-1 when nothing popped), front and back words (-1 when
// empty), count, empty flag and overflow for a push dropped when full.
// each item runs through these steps in order: accept, apply and read the
// popped entry from the store, read the front and back entries, load the
// result register. the next item is taken in the cycle after the result
// register is loaded, since the two store reads of one item follow its
// write through the single write port.
// the result register parts the channels: a new item is accepted while
// an earlier result waits; a stalled receiver holds the finished item
// until the result register is free.
// reset clears the indices, count and valid flags; store contents stay
// undefined and are only ever read where a word was written.
`default_nettype none
module ring_buffer_deque_top
    import rbdq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic        [FUNC_W-1:0] func,
    input  wire logic signed [WORD_W-1:0] push_word,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed      [WORD_W-1:0] popped_word,
    output logic signed      [WORD_W-1:0] head_word,
    output logic signed      [WORD_W-1:0] tail_word,
    output logic             [6:0]        count,
    output logic                          is_empty,
    output logic                          overflow
);

    rbdq_cmd_t cmd;

    rbdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rbdq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .push_word   (push_word),
        .popped_word (popped_word),
        .head_word   (head_word),
        .tail_word   (tail_word),
        .count       (count),
        .is_empty    (is_empty),
        .overflow    (overflow)
    );

endmodule
`default_nettype wire

FILE: tb/sv/ring_buffer_deque_top_tb.sv
// self-checking testbench for the ring buffer deque top level
`timescale 1ns / 1ps

module ring_buffer_deque_top_tb
    import rbdq_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam int OPS_TARGET = 750;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [WORD_W-1:0] popped;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
        logic [6:0]               cnt;
        logic                     empty;
        logic                     ovf;
    } deque_view_t;

    class deque_scoreboard;
        logic [WORD_W-1:0] words [DEPTH];
        int front_at;
        int back_end;
        int fill;
        int errors;
        deque_view_t views_due[$];

        function new();
            front_at = 0;
            back_end = 0;
            fill     = 0;
            errors   = 0;
        endfunction

        function int wrap_dec(int i);
            return (i == 0) ? DEPTH - 1 : i - 1;
        endfunction

        function int wrap_inc(int i);
            return (i + 1 >= DEPTH) ? 0 : i + 1;
        endfunction

        function void apply_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] w);
            deque_view_t v;
            v.popped = NO_WORD;
            v.front  = NO_WORD;
            v.back   = NO_WORD;
            v.ovf    = 1'b0;
            case (f)
                FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                begin
                    if (fill >= DEPTH)
                    begin
                        v.ovf = 1'b1;
                    end
                    else if (f == FUNC_PUSH_FRONT)
                    begin
                        front_at = wrap_dec(front_at);
                        words[front_at] = w;
                        fill++;
                    end
                    else
                    begin
                        words[back_end] = w;
                        back_end = wrap_inc(back_end);
                        fill++;
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (fill != 0)
                    begin
                        v.popped = words[front_at];
                        front_at = wrap_inc(front_at);
                        fill--;
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (fill != 0)
                    begin
                        back_end = wrap_dec(back_end);
                        v.popped = words[back_end];
                        fill--;
                    end
                end
                FUNC_CLEAR:
                begin
                    front_at = 0;
                    back_end = 0;
                    fill     = 0;
                end
                default:
                begin
                end
            endcase
            if (fill != 0)
            begin
                v.front = words[front_at];
                v.back  = words[wrap_dec(back_end)];
            end
            v.cnt   = 7'(fill);
            v.empty = (fill == 0);
            views_due.insert(views_due.size(), v);
        endfunction

        function void check_view(deque_view_t got);
            deque_view_t want;
            if (views_due.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            want = views_due[0];
            views_due.delete(0);
            if (got.popped !== want.popped)
            begin
                $error("popped_word: expected %0d, got %0d", want.popped, got.popped);
                errors++;
            end
            if (got.front !== want.front)
            begin
                $error("head_word: expected %0d, got %0d", want.front, got.front);
                errors++;
            end
            if (got.back !== want.back)
            begin
                $error("tail_word: expected %0d, got %0d", want.back, got.back);
                errors++;
            end
            if (got.cnt !== want.cnt)
            begin
                $error("count: expected %0d, got %0d", want.cnt, got.cnt);
                errors++;
            end
            if (got.empty !== want.empty)
            begin
                $error("is_empty: expected %0b, got %0b", want.empty, got.empty);
                errors++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic        [FUNC_W-1:0] func = FUNC_IDLE;
    logic signed [WORD_W-1:0] push_word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] popped_word;
    logic signed [WORD_W-1:0] head_word;
    logic signed [WORD_W-1:0] tail_word;
    logic        [6:0]        count;
    logic                     is_empty;
    logic                     overflow;

    deque_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ops_sent = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    ring_buffer_deque_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .push_word   (push_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .popped_word (popped_word),
        .head_word   (head_word),
        .tail_word   (tail_word),
        .count       (count),
        .is_empty    (is_empty),
        .overflow    (overflow)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // result is checked before the new item is noted
    always @(posedge clk)
    begin
        deque_view_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.popped = popped_word;
                got.front  = head_word;
                got.back   = tail_word;
                got.cnt    = count;
                got.empty  = is_empty;
                got.ovf    = overflow;
                sb.check_view(got);
            end
            if (in_valid && in_ready)
                sb.apply_op(func, push_word);
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        push_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (f != FUNC_IDLE && f <= FUNC_CLEAR)
            ops_sent++;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return FUNC_PUSH_BACK;
        else if (r < 54)
            return FUNC_PUSH_FRONT;
        else if (r < 72)
            return FUNC_POP_FRONT;
        else if (r < 90)
            return FUNC_POP_BACK;
        else if (r < 93)
            return FUNC_CLEAR;
        else if (r < 96)
            return FUNC_IDLE;
        else if (r < 98)
            return FUNC_SPARE_LO;
        else
            return FUNC_SPARE_HI;
    endfunction

    initial
    begin
        int kind;
        int n;
        bit first_run;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, unused codes, wrap of the head index, extremes
        send_op(FUNC_POP_FRONT, 32'h1234_5678);
        send_op(FUNC_POP_BACK, 32'h8765_4321);
        send_op(FUNC_IDLE, 32'hdead_beef);
        send_op(FUNC_SPARE_LO, 32'h1111_1111);
        send_op(FUNC_SPARE_HI, 32'h2222_2222);
        send_op(FUNC_PUSH_FRONT, 32'h8000_0000);
        send_op(FUNC_PUSH_BACK, 32'h7fff_ffff);
        send_op(FUNC_PUSH_FRONT, 32'hffff_ffff);
        send_op(FUNC_PUSH_BACK, 32'h0000_0000);
        send_op(FUNC_IDLE, 32'hffff_ffff);
        send_op(FUNC_POP_BACK, 32'h0);
        send_op(FUNC_POP_FRONT, 32'h0);
        send_op(FUNC_CLEAR, 32'h5a5a_5a5a);
        send_op(FUNC_POP_FRONT, 32'h0);
        send_op(FUNC_POP_BACK, 32'h0);
        send_op(FUNC_PUSH_BACK, 32'h5555_5555);
        send_op(FUNC_PUSH_FRONT, 32'haaaa_aaaa);
        send_op(FUNC_POP_FRONT, 32'h0);
        send_op(FUNC_POP_BACK, 32'h0);
        send_op(FUNC_POP_BACK, 32'h0);
        send_op(FUNC_PUSH_BACK, 32'h0000_0001);
        send_op(FUNC_CLEAR, 32'h0);
        send_op(FUNC_CLEAR, 32'h0);

        // long receiver hold as pushes that may pass capacity begin
        hold_req  = 1'b1;
        first_run = 1'b1;
        ops_sent  = 0;
        while (ops_sent < OPS_TARGET)
        begin
            case (ops_sent * 4 / OPS_TARGET)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            kind = first_run ? 0 : $urandom_range(0, 9);
            first_run = 1'b0;
            if (kind == 0)
            begin
                n = $urandom_range(60, 72);
                repeat (n)
                    send_op($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                            pick_word());
            end
            else if (kind <= 2)
            begin
                n = $urandom_range(10, 70);
                repeat (n)
                    send_op($urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK,
                            pick_word());
            end
            else if (kind <= 8)
            begin
                n = $urandom_range(5, 30);
                repeat (n)
                    send_op(pick_func(), pick_word());
            end
            else
            begin
                send_op($urandom_range(0, 1) ? FUNC_CLEAR : FUNC_IDLE, pick_word());
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.views_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
